// File: hw/rtl/tot_pkg.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term: shared types and constants
// Payload structs, sign-magnitude lanes and widths used along the pipeline.
// ----------------------------------------------------------------------------
package tot_pkg;

    localparam int InW      = 24;   // input component width, Q8.16
    localparam int MagW     = 31;   // normalized component and unit magnitudes
    localparam int R2W      = 62;   // normalized squared length
    localparam int RootW    = 31;   // square root of the normalized length
    localparam int NormStep = 5;    // binary normalization steps
    localparam int FMagW    = 36;   // gradient numerator magnitude
    localparam int NumW     = 69;   // numerator after the 2^(k+2) scale
    localparam int OutW     = 32;   // Q16.16 outputs

    typedef struct packed {
        logic signed [InW-1:0] vec_x;
        logic signed [InW-1:0] vec_y;
        logic signed [InW-1:0] vec_z;
    } tot_in_t;

    typedef struct packed {
        logic signed [OutW-1:0] order_value;
        logic signed [OutW-1:0] grad_x;
        logic signed [OutW-1:0] grad_y;
        logic signed [OutW-1:0] grad_z;
        logic                   zero_length;
    } tot_out_t;

    // Side information that rides along with each transaction.
    typedef struct packed {
        logic                   zero;
        logic [4:0]             k;
        logic signed [OutW-1:0] value;
    } tot_tag_t;

    typedef struct packed {
        logic [MagW-1:0] mag;
        logic            neg;
    } tot_sm_t;

    typedef tot_sm_t [2:0] tot_sm3_t;

    typedef struct packed {
        logic [FMagW-1:0] mag;
        logic             neg;
    } tot_f_t;

    typedef tot_f_t [2:0] tot_f3_t;

endpackage

// File: hw/rtl/tot_norm.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term: squared length and normalization
// Forms |x|^2+|y|^2+|z|^2 and shifts it by pairs of bits into [2^60, 2^62),
// scaling the component magnitudes by the same 2^k. Seven register stages.
// ----------------------------------------------------------------------------
module tot_norm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  tot_pkg::tot_in_t  in_data,
    output logic              out_valid,
    output tot_pkg::tot_tag_t tag_out,
    output logic [61:0]       r2_out,
    output tot_pkg::tot_sm3_t mag_out
);
    import tot_pkg::*;

    localparam int NS = NormStep + 1;

    logic [InW-1:0]   raw [3];
    logic [InW-1:0]   abs_v [3];
    logic [47:0]      sq_next [3];
    logic [47:0]      sq_reg [3];
    tot_sm_t          m0_reg [3];
    logic             v0_reg;

    logic [R2W-1:0]   r2_reg [NS];
    logic [R2W-1:0]   r2_next [NS];
    tot_sm3_t         m_reg [NS];
    tot_sm3_t         m_next [NS];
    logic [4:0]       k_reg [NS];
    logic [4:0]       k_next [NS];
    logic             zero_reg [NS];
    logic             v_reg [NS];

    always_comb begin
        raw[0] = in_data.vec_x;
        raw[1] = in_data.vec_y;
        raw[2] = in_data.vec_z;
        for (int l = 0; l < 3; l++) begin
            abs_v[l]   = raw[l][InW-1] ? (~raw[l] + InW'(1)) : raw[l];
            sq_next[l] = abs_v[l] * abs_v[l];
        end
    end

    // Each step shifts by 2*s bits when the top 2*s bits of the window are clear.
    always_comb begin
        int s;
        r2_next[0] = {14'd0, sq_reg[0] + sq_reg[1] + sq_reg[2]};
        k_next[0]  = '0;
        for (int l = 0; l < 3; l++) begin
            m_next[0][l] = m0_reg[l];
        end
        for (int i = 0; i < NormStep; i++) begin
            s = 16 >> i;
            if ((r2_reg[i] >> (R2W - 2 * s)) == '0) begin
                r2_next[i+1] = r2_reg[i] << (2 * s);
                k_next[i+1]  = k_reg[i] + 5'(s);
                for (int l = 0; l < 3; l++) begin
                    m_next[i+1][l].mag = m_reg[i][l].mag << s;
                    m_next[i+1][l].neg = m_reg[i][l].neg;
                end
            end else begin
                r2_next[i+1] = r2_reg[i];
                k_next[i+1]  = k_reg[i];
                m_next[i+1]  = m_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            v0_reg   <= in_valid;
            v_reg[0] <= v0_reg;
            for (int i = 1; i < NS; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 3; l++) begin
                sq_reg[l]     <= sq_next[l];
                m0_reg[l].mag <= MagW'(abs_v[l]);
                m0_reg[l].neg <= raw[l][InW-1];
            end
            zero_reg[0] <= (r2_next[0] == '0);
            for (int i = 1; i < NS; i++) begin
                zero_reg[i] <= zero_reg[i-1];
            end
            for (int i = 0; i < NS; i++) begin
                r2_reg[i] <= r2_next[i];
                k_reg[i]  <= k_next[i];
                m_reg[i]  <= m_next[i];
            end
        end
    end

    assign out_valid     = v_reg[NS-1];
    assign tag_out.zero  = zero_reg[NS-1];
    assign tag_out.k     = k_reg[NS-1];
    assign tag_out.value = '0;
    assign r2_out        = r2_reg[NS-1];
    assign mag_out       = m_reg[NS-1];

endmodule

// File: hw/rtl/tot_sqrt.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term: pipelined integer square root
// Digit-by-digit root of the normalized squared length, one root bit per
// register stage, 31 stages.
// ----------------------------------------------------------------------------
module tot_sqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  tot_pkg::tot_tag_t tag_in,
    input  logic [61:0]       r2_in,
    input  tot_pkg::tot_sm3_t mag_in,
    output logic              out_valid,
    output tot_pkg::tot_tag_t tag_out,
    output logic [30:0]       root_out,
    output tot_pkg::tot_sm3_t mag_out
);
    import tot_pkg::*;

    localparam int N = RootW;

    logic [R2W-1:0] n_cur [N];
    logic [R2W-1:0] n_next [N];
    logic [R2W-1:0] n_reg [N];
    logic [R2W:0]   rt_cur [N];
    logic [R2W:0]   rt_next [N];
    logic [R2W:0]   rt_reg [N];
    tot_tag_t       tag_reg [N];
    tot_sm3_t       mag_reg [N];
    logic           v_reg [N];

    always_comb begin
        logic [R2W:0] bitv;
        logic [R2W:0] trial;
        n_cur[0]  = r2_in;
        rt_cur[0] = '0;
        for (int i = 1; i < N; i++) begin
            n_cur[i]  = n_reg[i-1];
            rt_cur[i] = rt_reg[i-1];
        end
        for (int i = 0; i < N; i++) begin
            bitv  = (R2W+1)'(1) << (2 * (N - 1 - i));
            trial = rt_cur[i] + bitv;
            if ({1'b0, n_cur[i]} >= trial) begin
                n_next[i]  = n_cur[i] - trial[R2W-1:0];
                rt_next[i] = (rt_cur[i] >> 1) + bitv;
            end else begin
                n_next[i]  = n_cur[i];
                rt_next[i] = rt_cur[i] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < N; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tag_reg[0] <= tag_in;
            mag_reg[0] <= mag_in;
            for (int i = 1; i < N; i++) begin
                tag_reg[i] <= tag_reg[i-1];
                mag_reg[i] <= mag_reg[i-1];
            end
            for (int i = 0; i < N; i++) begin
                n_reg[i]  <= n_next[i];
                rt_reg[i] <= rt_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign tag_out   = tag_reg[N-1];
    assign root_out  = rt_reg[N-1][RootW-1:0];
    assign mag_out   = mag_reg[N-1];

endmodule

// File: hw/rtl/tot_unit.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term: unit vector dividers
// Three restoring dividers, one quotient bit per stage, form |c'| * 2^30 / R'
// in Q1.30. The component never exceeds R', so 31 quotient bits suffice.
// ----------------------------------------------------------------------------
module tot_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  tot_pkg::tot_tag_t tag_in,
    input  logic [30:0]       root_in,
    input  tot_pkg::tot_sm3_t mag_in,
    output logic              out_valid,
    output tot_pkg::tot_tag_t tag_out,
    output logic [30:0]       root_out,
    output tot_pkg::tot_sm3_t unit_out
);
    import tot_pkg::*;

    localparam int N = MagW;

    logic [MagW:0]    rem_cur [N][3];
    logic [MagW:0]    rem_next [N][3];
    logic [MagW:0]    rem_reg [N][3];
    logic [MagW-1:0]  q_cur [N][3];
    logic [MagW-1:0]  q_next [N][3];
    logic [MagW-1:0]  q_reg [N][3];
    logic [RootW-1:0] rp_cur [N];
    logic [RootW-1:0] rp_reg [N];
    logic [2:0]       neg_reg [N];
    tot_tag_t         tag_reg [N];
    logic             v_reg [N];

    always_comb begin
        logic ge;
        rp_cur[0] = root_in;
        for (int l = 0; l < 3; l++) begin
            rem_cur[0][l] = {1'b0, mag_in[l].mag};
            q_cur[0][l]   = '0;
        end
        for (int i = 1; i < N; i++) begin
            rp_cur[i] = rp_reg[i-1];
            for (int l = 0; l < 3; l++) begin
                rem_cur[i][l] = {rem_reg[i-1][l][MagW-1:0], 1'b0};
                q_cur[i][l]   = q_reg[i-1][l];
            end
        end
        for (int i = 0; i < N; i++) begin
            for (int l = 0; l < 3; l++) begin
                ge             = rem_cur[i][l] >= {1'b0, rp_cur[i]};
                rem_next[i][l] = ge ? rem_cur[i][l] - {1'b0, rp_cur[i]} : rem_cur[i][l];
                q_next[i][l]   = {q_cur[i][l][MagW-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < N; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tag_reg[0] <= tag_in;
            neg_reg[0] <= {mag_in[2].neg, mag_in[1].neg, mag_in[0].neg};
            for (int i = 1; i < N; i++) begin
                tag_reg[i] <= tag_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
            for (int i = 0; i < N; i++) begin
                rp_reg[i] <= rp_cur[i];
                for (int l = 0; l < 3; l++) begin
                    rem_reg[i][l] <= rem_next[i][l];
                    q_reg[i][l]   <= q_next[i][l];
                end
            end
        end
    end

    // A zero quotient carries no sign.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            unit_out[l].mag = q_reg[N-1][l];
            unit_out[l].neg = neg_reg[N-1][l] && (q_reg[N-1][l] != '0);
        end
    end

    assign out_valid = v_reg[N-1];
    assign tag_out   = tag_reg[N-1];
    assign root_out  = rp_reg[N-1];

endmodule

// File: hw/rtl/tot_poly.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term: Q30 product stages
// Three stages of truncating Q30 products: pairwise products and squares,
// then the triple product and the 1 - 3u^2 factors, then the order value
// and the three gradient numerators 24 * (a*b) * c.
// ----------------------------------------------------------------------------
module tot_poly (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  tot_pkg::tot_tag_t tag_in,
    input  logic [30:0]       root_in,
    input  tot_pkg::tot_sm3_t unit_in,
    output logic              out_valid,
    output tot_pkg::tot_tag_t tag_out,
    output logic [30:0]       root_out,
    output tot_pkg::tot_f3_t  f_out
);
    import tot_pkg::*;

    // Stage 1: pairwise products (yz, xz, xy) and squares.
    logic [61:0]      pp [3];
    logic [61:0]      sp [3];
    logic [MagW-1:0]  p1_reg [3];
    logic [2:0]       p1n_reg;
    logic [MagW-1:0]  sq1_reg [3];
    tot_sm_t          uz1_reg;
    tot_tag_t         tag1_reg;
    logic [RootW-1:0] rp1_reg;

    // Stage 2: triple product and c factors.
    tot_sm_t          p2_reg [3];
    logic [MagW-1:0]  t2_reg;
    logic             t2n_reg;
    logic [31:0]      c2_reg [3];
    logic [2:0]       c2n_reg;
    tot_tag_t         tag2_reg;
    logic [RootW-1:0] rp2_reg;

    // Stage 3 outputs.
    tot_f3_t          f3_reg;
    tot_tag_t         tag3_reg;
    logic [RootW-1:0] rp3_reg;

    logic [2:0]       v_reg;

    always_comb begin
        pp[0] = unit_in[1].mag * unit_in[2].mag;
        pp[1] = unit_in[0].mag * unit_in[2].mag;
        pp[2] = unit_in[0].mag * unit_in[1].mag;
        for (int l = 0; l < 3; l++) begin
            sp[l] = unit_in[l].mag * unit_in[l].mag;
        end
    end

    tot_sm_t     p_fix [3];
    logic [61:0] tp;
    logic [33:0] three_sq [3];
    logic [33:0] cd [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            p_fix[l].mag = p1_reg[l];
            p_fix[l].neg = p1n_reg[l] && (p1_reg[l] != '0);
            three_sq[l]  = {3'd0, sq1_reg[l]} + {2'd0, sq1_reg[l], 1'b0};
            cd[l]        = (34'd1 << 30) - three_sq[l];
        end
        tp = p1_reg[2] * uz1_reg.mag;
    end

    logic [62:0] mp [3];
    logic [31:0] m1 [3];
    logic [34:0] t24;
    logic [20:0] sv;
    logic        tneg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            mp[l] = p2_reg[l].mag * c2_reg[l];
            m1[l] = mp[l][61:30];
        end
        tneg = t2n_reg && (t2_reg != '0);
        t24  = {t2_reg, 4'd0} + {1'b0, t2_reg, 3'd0};
        sv   = t24[34:14];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 3; l++) begin
                p1_reg[l]  <= pp[l][60:30];
                sq1_reg[l] <= sp[l][60:30];
            end
            p1n_reg  <= {unit_in[0].neg ^ unit_in[1].neg,
                         unit_in[0].neg ^ unit_in[2].neg,
                         unit_in[1].neg ^ unit_in[2].neg};
            uz1_reg  <= unit_in[2];
            tag1_reg <= tag_in;
            rp1_reg  <= root_in;

            for (int l = 0; l < 3; l++) begin
                p2_reg[l]  <= p_fix[l];
                c2n_reg[l] <= cd[l][33];
                c2_reg[l]  <= cd[l][33] ? 32'(-cd[l]) : cd[l][31:0];
            end
            t2_reg   <= tp[60:30];
            t2n_reg  <= p_fix[2].neg ^ uz1_reg.neg;
            tag2_reg <= tag1_reg;
            rp2_reg  <= rp1_reg;

            for (int l = 0; l < 3; l++) begin
                f3_reg[l].mag <= {m1[l], 4'd0} + {1'b0, m1[l], 3'd0};
                f3_reg[l].neg <= (p2_reg[l].neg ^ c2n_reg[l]) && (m1[l] != '0);
            end
            tag3_reg.zero  <= tag2_reg.zero;
            tag3_reg.k     <= tag2_reg.k;
            tag3_reg.value <= tneg ? -OutW'(sv) : OutW'(sv);
            rp3_reg        <= rp2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign tag_out   = tag3_reg;
    assign root_out  = rp3_reg;
    assign f_out     = f3_reg;

endmodule

// File: hw/rtl/tot_grad.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term: gradient scaling dividers
// Scales each numerator by 2^(k+2), detects a quotient beyond the Q16.16
// range up front, then divides by R' one quotient bit per stage (31 stages).
// ----------------------------------------------------------------------------
module tot_grad (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ce,
    input  logic                   in_valid,
    input  tot_pkg::tot_tag_t      tag_in,
    input  logic [30:0]            root_in,
    input  tot_pkg::tot_f3_t       f_in,
    output logic                   out_valid,
    output tot_pkg::tot_tag_t      tag_out,
    output logic signed [31:0]     grad_out [3]
);
    import tot_pkg::*;

    localparam int N  = 31;
    localparam int LW = 31;

    logic [NumW-1:0]  num0_reg [3];
    logic [2:0]       neg0_reg;
    tot_tag_t         tag0_reg;
    logic [RootW-1:0] rp0_reg;
    logic             v0_reg;
    logic [5:0]       sh;

    logic [RootW-1:0] rem_cur [N][3];
    logic [RootW-1:0] rem_next [N][3];
    logic [RootW-1:0] rem_reg [N][3];
    logic [LW-1:0]    low_cur [N][3];
    logic [LW-1:0]    low_reg [N][3];
    logic [N-1:0]     q_cur [N][3];
    logic [N-1:0]     q_next [N][3];
    logic [N-1:0]     q_reg [N][3];
    logic [RootW-1:0] rp_cur [N];
    logic [RootW-1:0] rp_reg [N];
    logic [2:0]       sat_cur [N];
    logic [2:0]       sat_reg [N];
    logic [2:0]       neg_reg [N];
    tot_tag_t         tag_reg [N];
    logic             v_reg [N];

    assign sh = {1'b0, tag_in.k} + 6'd2;

    always_comb begin
        logic [RootW:0] r;
        logic           ge;
        rp_cur[0] = rp0_reg;
        for (int l = 0; l < 3; l++) begin
            // Quotient reaches 2^31 exactly when num / 2^31 is at least R'.
            sat_cur[0][l] = num0_reg[l][NumW-1:LW] >= {7'd0, rp0_reg};
            rem_cur[0][l] = num0_reg[l][LW+RootW-1:LW];
            low_cur[0][l] = num0_reg[l][LW-1:0];
            q_cur[0][l]   = '0;
        end
        for (int i = 1; i < N; i++) begin
            rp_cur[i]  = rp_reg[i-1];
            sat_cur[i] = sat_reg[i-1];
            for (int l = 0; l < 3; l++) begin
                rem_cur[i][l] = rem_reg[i-1][l];
                low_cur[i][l] = low_reg[i-1][l] << 1;
                q_cur[i][l]   = q_reg[i-1][l];
            end
        end
        for (int i = 0; i < N; i++) begin
            for (int l = 0; l < 3; l++) begin
                r              = {rem_cur[i][l], low_cur[i][l][LW-1]};
                ge             = r >= {1'b0, rp_cur[i]};
                rem_next[i][l] = ge ? RootW'(r - {1'b0, rp_cur[i]}) : r[RootW-1:0];
                q_next[i][l]   = {q_cur[i][l][N-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            for (int i = 0; i < N; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            v0_reg   <= in_valid;
            v_reg[0] <= v0_reg;
            for (int i = 1; i < N; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 3; l++) begin
                num0_reg[l] <= NumW'(f_in[l].mag) << sh;
                neg0_reg[l] <= f_in[l].neg;
            end
            tag0_reg <= tag_in;
            rp0_reg  <= root_in;

            tag_reg[0] <= tag0_reg;
            neg_reg[0] <= neg0_reg;
            for (int i = 1; i < N; i++) begin
                tag_reg[i] <= tag_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
            for (int i = 0; i < N; i++) begin
                rp_reg[i]  <= rp_cur[i];
                sat_reg[i] <= sat_cur[i];
                for (int l = 0; l < 3; l++) begin
                    rem_reg[i][l] <= rem_next[i][l];
                    low_reg[i][l] <= low_cur[i][l];
                    q_reg[i][l]   <= q_next[i][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (sat_reg[N-1][l]) begin
                grad_out[l] = neg_reg[N-1][l] ? {1'b1, {(OutW-1){1'b0}}}
                                              : {1'b0, {(OutW-1){1'b1}}};
            end else if (neg_reg[N-1][l]) begin
                grad_out[l] = -{1'b0, q_reg[N-1][l]};
            end else begin
                grad_out[l] = {1'b0, q_reg[N-1][l]};
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign tag_out   = tag_reg[N-1];

endmodule

// File: hw/rtl/tetrahedral_order_term.sv
// ----------------------------------------------------------------------------
// Tetrahedral order term of one distance vector
// Returns 24*ux*uy*uz and its gradient for a Q8.16 vector, in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one vector (vec_x, vec_y, vec_z) per transaction;
//   the m_ channel returns one result per input, in order, with the order
//   value, the three saturated gradient components and the zero_length flag.
//   A zero vector returns zero values with zero_length set.
//   Throughput is one transaction per cycle while m_ready does not stall the
//   output. Results pass through the squared length and normalization, the
//   bit-per-stage square root, the unit vector dividers, the products, the
//   gradient scaling and dividers and the output register.
//   The whole pipeline advances together: when a result waits at the output
//   and m_ready is low, every stage holds and s_ready drops; nothing is lost
//   or repeated. Reset clears all valid bits, so no result is presented
//   until new input arrives.
// ----------------------------------------------------------------------------
module tetrahedral_order_term (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tot_pkg::tot_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output tot_pkg::tot_out_t m_payload
);
    import tot_pkg::*;

    logic     ce;
    logic     nv, sv, uv, pv, gv;
    tot_tag_t ntag, stag, utag, ptag, gtag;
    logic [R2W-1:0]   n_r2;
    tot_sm3_t         n_mag, s_mag, u_unit;
    logic [RootW-1:0] s_root, u_root, p_root;
    tot_f3_t          p_f;
    logic signed [OutW-1:0] g_grad [3];

    logic     m_valid_reg;
    tot_out_t m_payload_reg;
    tot_out_t m_payload_next;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    tot_norm u_norm (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(s_valid),
        .in_data(s_payload), .out_valid(nv), .tag_out(ntag),
        .r2_out(n_r2), .mag_out(n_mag)
    );

    tot_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(nv),
        .tag_in(ntag), .r2_in(n_r2), .mag_in(n_mag), .out_valid(sv),
        .tag_out(stag), .root_out(s_root), .mag_out(s_mag)
    );

    tot_unit u_unit_div (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(sv),
        .tag_in(stag), .root_in(s_root), .mag_in(s_mag), .out_valid(uv),
        .tag_out(utag), .root_out(u_root), .unit_out(u_unit)
    );

    tot_poly u_poly (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(uv),
        .tag_in(utag), .root_in(u_root), .unit_in(u_unit), .out_valid(pv),
        .tag_out(ptag), .root_out(p_root), .f_out(p_f)
    );

    tot_grad u_grad (
        .aclk(aclk), .aresetn(aresetn), .ce(ce), .in_valid(pv),
        .tag_in(ptag), .root_in(p_root), .f_in(p_f), .out_valid(gv),
        .tag_out(gtag), .grad_out(g_grad)
    );

    always_comb begin
        if (gtag.zero) begin
            m_payload_next = '0;
            m_payload_next.zero_length = 1'b1;
        end else begin
            m_payload_next.order_value = gtag.value;
            m_payload_next.grad_x      = g_grad[0];
            m_payload_next.grad_y      = g_grad[1];
            m_payload_next.grad_z      = g_grad[2];
            m_payload_next.zero_length = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= gv;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.zero_length |->
            m_payload.order_value == '0 && m_payload.grad_x == '0 &&
            m_payload.grad_y == '0 && m_payload.grad_z == '0)
        else $error("zero-length result carries nonzero data");

    a_value_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.order_value <= 32'sd1572864 &&
                    m_payload.order_value >= -32'sd1572864)
        else $error("order value outside the range of 24*|t|/2^14");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while the pipeline is stalled");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented right after reset");
`endif

endmodule
